[hw/rtl/tlpg_pkg.sv]
// Package: payload types, command and register codes, and map dimension tables.
package tlpg_pkg;

   localparam int TileAddrW   = 12;   // tile RAM, 4096 words
   localparam int ScrollAddrW = 10;   // row and column scroll RAMs, 1024 words
   localparam int MapW        = 12;   // map coordinate width, widest map is 4096 pixels
   localparam logic [TileAddrW:0] BankOffset = 13'h1000;

   typedef enum logic [2:0] {
      CMD_TILE_WR = 3'd0,
      CMD_ROW_WR  = 3'd1,
      CMD_COL_WR  = 3'd2,
      CMD_PIX_WR  = 3'd3,
      CMD_RENDER  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      REG_LAYER_MODE  = 3'd0,
      REG_WIDE_TYPE   = 3'd1,
      REG_SCROLL_X    = 3'd2,
      REG_SCROLL_Y    = 3'd3,
      REG_Y_ADJUST    = 3'd4,
      REG_COLOR_BASE  = 3'd5,
      REG_GFX_MASK    = 3'd6,
      REG_COLOR_SHIFT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [19:0] addr;
      logic [15:0] wdata;
      logic [8:0]  screen_x;
      logic [8:0]  screen_y;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] pixel_value;
      logic        draw;
   } rsp_payload_type;

   // Log2 of map width and height in tiles, by table row and shape.
   // Shape 3 repeats shape 1.
   localparam logic [3:0] MapWideLog [4][4] = '{
      '{4'd7, 4'd6, 4'd5, 4'd6},
      '{4'd6, 4'd5, 4'd4, 4'd5},
      '{4'd7, 4'd6, 4'd5, 4'd6},
      '{4'd8, 4'd7, 4'd6, 4'd7}
   };
   localparam logic [3:0] MapHighLog [4][4] = '{
      '{4'd5, 4'd6, 4'd7, 4'd6},
      '{4'd4, 4'd5, 4'd6, 4'd5},
      '{4'd4, 4'd5, 4'd6, 4'd5},
      '{4'd4, 4'd5, 4'd6, 4'd5}
   };

endpackage

[hw/rtl/tlpg_ram.sv]
// Generic RAM: one write port, one read port with registered read data.
module tlpg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tilemap_layer_pixel_generator.sv]
// Scrolling tilemap layer: memory write commands and a five-stage per-pixel render pipeline.
//
//   channel  | ports                              | direction | moves
//   ---------+------------------------------------+-----------+--------------------------
//   req      | req_valid req_ready req_payload    | in        | write command or render
//   rsp      | rsp_valid rsp_ready rsp_payload    | out       | one pixel per render
//   csr      | csr_valid csr_ready csr_index/data | in        | register write
//
// One item per cycle while the pipeline advances. A render result moves through s1 to s4 into
// the output register; column scroll RAM, row scroll RAM, tile RAM and pixel ROM are read in
// that order, one synchronous read each. Every write command writes its memory in the stage
// where that memory is read, so reads and writes stay in stream order without forwarding.
// Reset sets the configuration registers to their defaults, clears the pipeline valid bits
// and holds req_ready low; memories are not cleared.
// The whole pipeline holds only when a render waits in the last stage while the output
// register is full and not taken; csr_ready is always high.
module tilemap_layer_pixel_generator #(
   parameter int GFX_PIXELS = 1048576
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tlpg_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tlpg_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_data
);

   import tlpg_pkg::*;

   localparam int GfxAddrW = $clog2(GFX_PIXELS);

   // One item in flight; fields fill in as it moves down the pipeline.
   typedef struct packed {
      logic            valid;
      logic [2:0]      cmd;
      logic [19:0]     addr;
      logic [15:0]     wdata;
      logic [MapW-1:0] syy;
      logic [MapW-1:0] sxx;
      logic [3:0]      zy;
      logic [3:0]      zx;
      logic [3:0]      colr;
   } item_type;

   function automatic logic [MapW-1:0] low_mask(input logic [3:0] bits);
      return MapW'((13'd1 << bits) - 13'd1);
   endfunction

   // ---------------- configuration registers ----------------
   logic [6:0]  layer_mode_ff,  layer_mode_in;
   logic [1:0]  wide_type_ff,   wide_type_in;
   logic [15:0] scroll_x_ff,    scroll_x_in;
   logic [15:0] scroll_y_ff,    scroll_y_in;
   logic [8:0]  y_adjust_ff,    y_adjust_in;
   logic [15:0] color_base_ff,  color_base_in;
   logic [12:0] gfx_mask_ff,    gfx_mask_in;
   logic [3:0]  color_shift_ff, color_shift_in;

   assign csr_ready = 1'b1;

   always_comb begin
      layer_mode_in  = layer_mode_ff;
      wide_type_in   = wide_type_ff;
      scroll_x_in    = scroll_x_ff;
      scroll_y_in    = scroll_y_ff;
      y_adjust_in    = y_adjust_ff;
      color_base_in  = color_base_ff;
      gfx_mask_in    = gfx_mask_ff;
      color_shift_in = color_shift_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_LAYER_MODE:  layer_mode_in  = csr_data[6:0];
            REG_WIDE_TYPE:   wide_type_in   = csr_data[1:0];
            REG_SCROLL_X:    scroll_x_in    = csr_data;
            REG_SCROLL_Y:    scroll_y_in    = csr_data;
            REG_Y_ADJUST:    y_adjust_in    = csr_data[8:0];
            REG_COLOR_BASE:  color_base_in  = csr_data;
            REG_GFX_MASK:    gfx_mask_in    = csr_data[12:0];
            REG_COLOR_SHIFT: color_shift_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_mode_ff  <= '0;
         wide_type_ff   <= '0;
         scroll_x_ff    <= '0;
         scroll_y_ff    <= '0;
         y_adjust_ff    <= '0;
         color_base_ff  <= '0;
         gfx_mask_ff    <= 13'hfff;
         color_shift_ff <= 4'd4;
      end else begin
         layer_mode_ff  <= layer_mode_in;
         wide_type_ff   <= wide_type_in;
         scroll_x_ff    <= scroll_x_in;
         scroll_y_ff    <= scroll_y_in;
         y_adjust_ff    <= y_adjust_in;
         color_base_ff  <= color_base_in;
         gfx_mask_ff    <= gfx_mask_in;
         color_shift_ff <= color_shift_in;
      end
   end

   // ---------------- layer geometry, static between items ----------------
   logic            big;
   logic [1:0]      trow;
   logic [3:0]      tile_log;
   logic [3:0]      wide_log;
   logic [3:0]      high_log;
   logic [3:0]      bank_log;
   logic [MapW-1:0] mw;
   logic [MapW-1:0] mh;
   logic            row_scroll_en;
   logic            col_scroll_en;
   logic            opaque;

   always_comb begin
      big      = layer_mode_ff[0];
      // wide_type above 2 acts as 2
      trow     = big ? ((wide_type_ff > 2'd2) ? 2'd3 : wide_type_ff + 2'd1) : 2'd0;
      tile_log = big ? 4'd4 : 4'd3;
      wide_log = MapWideLog[trow][layer_mode_ff[2:1]];
      high_log = MapHighLog[trow][layer_mode_ff[2:1]];
      bank_log = MapHighLog[trow][0];
      mw       = low_mask(4'(wide_log + tile_log));
      mh       = low_mask(4'(high_log + tile_log));
      row_scroll_en = layer_mode_ff[4];
      col_scroll_en = layer_mode_ff[5];
      opaque        = layer_mode_ff[6];
   end

   // ---------------- pipeline control ----------------
   item_type s1_ff, s1_in;
   item_type s2_ff, s2_in;
   item_type s3_ff, s3_in;
   item_type s4_ff, s4_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic     s4_render;
   logic     advance;
   logic     req_xfer;

   assign s4_render = s4_ff.valid && (s4_ff.cmd == CMD_RENDER);
   assign advance   = !(s4_render && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance && !reset;
   assign req_xfer  = req_valid && req_ready;

   // ---------------- stage 0: scroll, wrap, column scroll read ----------------
   logic [MapW-1:0] yadj;
   logic [MapW-1:0] syy0;
   logic [MapW-1:0] sxx0;
   logic [15:0]     col_rd;

   always_comb begin
      yadj = {{(MapW-9){y_adjust_ff[8]}}, y_adjust_ff};
      syy0 = (MapW'(req_payload.screen_y) + ((scroll_y_ff[MapW-1:0] + yadj) & mh)) & mh;
      sxx0 = (MapW'(req_payload.screen_x) + (scroll_x_ff[MapW-1:0] & mw)) & mw;
      s1_in       = '0;
      s1_in.valid = req_xfer;
      s1_in.cmd   = req_payload.cmd;
      s1_in.addr  = req_payload.addr;
      s1_in.wdata = req_payload.wdata;
      s1_in.syy   = syy0;
      s1_in.sxx   = sxx0;
   end

   tlpg_ram #(.WIDTH(16), .DEPTH(1 << ScrollAddrW)) u_col_scroll_ram (
      .clock   (clock),
      .wr_en   (req_xfer && (req_payload.cmd == CMD_COL_WR)),
      .wr_addr (req_payload.addr[ScrollAddrW-1:0]),
      .wr_data (req_payload.wdata),
      .rd_en   (advance),
      .rd_addr (syy0[ScrollAddrW-1:0]),
      .rd_data (col_rd)
   );

   // ---------------- stage 1: column scroll add, row scroll read ----------------
   logic [MapW-1:0] syy1;
   logic [15:0]     row_rd;

   always_comb begin
      syy1 = col_scroll_en ? ((s1_ff.syy + col_rd[MapW-1:0]) & mh) : s1_ff.syy;
      s2_in     = s1_ff;
      s2_in.syy = syy1;
   end

   tlpg_ram #(.WIDTH(16), .DEPTH(1 << ScrollAddrW)) u_row_scroll_ram (
      .clock   (clock),
      .wr_en   (advance && s1_ff.valid && (s1_ff.cmd == CMD_ROW_WR)),
      .wr_addr (s1_ff.addr[ScrollAddrW-1:0]),
      .wr_data (s1_ff.wdata),
      .rd_en   (advance),
      .rd_addr (syy1[ScrollAddrW-1:0]),
      .rd_data (row_rd)
   );

   // ---------------- stage 2: row scroll add, tile offset, tile read ----------------
   logic [MapW-1:0] sxx2;
   logic [MapW-1:0] tile_row;
   logic [MapW-1:0] tile_col;
   logic [15:0]     bank_mask;
   logic [15:0]     offs;
   logic [15:0]     tile_rd;

   always_comb begin
      sxx2      = row_scroll_en ? ((s2_ff.sxx + row_rd[MapW-1:0]) & mw) : s2_ff.sxx;
      tile_row  = s2_ff.syy >> tile_log;
      tile_col  = sxx2 >> tile_log;
      bank_mask = 16'((17'd1 << bank_log) - 17'd1);
      // map blocks are bank-wide column strips stacked one after another
      offs      = (16'(tile_col) & bank_mask)
                + (16'(tile_row) << bank_log)
                + ((16'(tile_col) & ~bank_mask) << high_log);
      s3_in     = s2_ff;
      s3_in.sxx = sxx2;
      s3_in.zy  = big ? s2_ff.syy[3:0] : {1'b0, s2_ff.syy[2:0]};
      s3_in.zx  = big ? sxx2[3:0] : {1'b0, sxx2[2:0]};
   end

   tlpg_ram #(.WIDTH(16), .DEPTH(1 << TileAddrW)) u_tile_ram (
      .clock   (clock),
      .wr_en   (advance && s2_ff.valid && (s2_ff.cmd == CMD_TILE_WR)),
      .wr_addr (s2_ff.addr[TileAddrW-1:0]),
      .wr_data (s2_ff.wdata),
      .rd_en   (advance),
      .rd_addr (offs[TileAddrW-1:0]),
      .rd_data (tile_rd)
   );

   // ---------------- stage 3: code mask, pixel address, pixel read ----------------
   logic [12:0]         code;
   logic [23:0]         paddr_full;
   logic [23:0]         waddr_full;
   logic [7:0]          pix_rd;

   always_comb begin
      code = (13'(tile_rd[11:0]) + (layer_mode_ff[3] ? BankOffset : 13'd0)) & gfx_mask_ff;
      paddr_full = big ? {3'b0, code, s3_ff.zy, s3_ff.zx}
                       : {5'b0, code, s3_ff.zy[2:0], s3_ff.zx[2:0]};
      waddr_full = {4'b0, s3_ff.addr};
      s4_in      = s3_ff;
      s4_in.colr = tile_rd[15:12];
   end

   tlpg_ram #(.WIDTH(8), .DEPTH(GFX_PIXELS)) u_pixel_rom (
      .clock   (clock),
      .wr_en   (advance && s3_ff.valid && (s3_ff.cmd == CMD_PIX_WR)),
      .wr_addr (waddr_full[GfxAddrW-1:0]),
      .wr_data (s3_ff.wdata[7:0]),
      .rd_en   (advance),
      .rd_addr (paddr_full[GfxAddrW-1:0]),
      .rd_data (pix_rd)
   );

   // ---------------- stage 4: colour and draw flag into the output register ----------------
   logic [15:0] color;

   always_comb begin
      color = ({12'b0, s4_ff.colr} << color_shift_ff) | color_base_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (advance && s4_render) begin
         rsp_valid_in = 1'b1;
         if ((pix_rd != 8'd0) || opaque) begin
            rsp_payload_in.pixel_value = 16'(pix_rd) + color;
            rsp_payload_in.draw        = 1'b1;
         end else begin
            // transparent pixel reports zero
            rsp_payload_in.pixel_value = '0;
            rsp_payload_in.draw        = 1'b0;
         end
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_ff.valid  <= 1'b0;
         s4_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_ff <= s1_in;
            s2_ff <= s2_in;
            s3_ff <= s3_in;
            s4_ff <= s4_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[sim/tilemap_layer_pixel_generator_tb.sv]
// Self-checking testbench for the tilemap layer pixel generator: directed and random traffic.
module tilemap_layer_pixel_generator_tb;
   import tlpg_pkg::*;

   localparam int unsigned GfxPixels   = 1048576;
   localparam int unsigned TileWords   = 4096;
   localparam int unsigned ScrollWords = 1024;
   localparam int unsigned BankAdd     = 32'h1000;
   localparam int          IdleCycles  = 8;     // pipeline depth plus margin
   localparam int          DrainCycles = 12;
   localparam int          DrainLimit  = 5000;
   localparam logic [2:0]  CmdSpareFirst = 3'd5;
   localparam logic [2:0]  CmdSpareLast  = 3'd7;

   // Map size in tiles: [table row][shape][width, height]. Row 0 serves 8x8 tiles,
   // rows 1..3 serve 16x16 tiles by wide type.
   localparam int unsigned MapTiles [4][3][2] = '{
      '{'{128, 32}, '{64, 64}, '{32, 128}},
      '{'{64, 16},  '{32, 32}, '{16, 64}},
      '{'{128, 16}, '{64, 32}, '{32, 64}},
      '{'{256, 16}, '{128, 32}, '{64, 64}}
   };

   typedef struct {
      logic [15:0] mode;
      logic [15:0] wide;
      logic [15:0] scroll_x;
      logic [15:0] scroll_y;
      logic [15:0] y_adjust;
      logic [15:0] color_base;
      logic [15:0] gfx_mask;
      logic [15:0] color_shift;
   } layer_cfg_type;

   // Memory indexes touched by one render, plus the pixel it yields.
   typedef struct {
      bit              uses_col;
      int unsigned     col_idx;
      bit              uses_row;
      int unsigned     row_idx;
      int unsigned     tile_idx;
      int unsigned     pix_addr;
      rsp_payload_type pixel;
   } pixel_path_type;

   localparam layer_cfg_type ResetCfg = '{16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0000, 16'h0000, 16'h0fff, 16'h0004};

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [2:0]      csr_index;
   logic [15:0]     csr_data;

   // Shadow of the layer registers.
   logic [6:0]  lyr_mode;
   logic [1:0]  lyr_wide;
   logic [15:0] lyr_scroll_x;
   logic [15:0] lyr_scroll_y;
   logic [8:0]  lyr_y_adjust;
   logic [15:0] lyr_color_base;
   logic [12:0] lyr_gfx_mask;
   logic [3:0]  lyr_color_shift;

   // Shadow of the memories, with a written flag per entry.
   logic [15:0] tile_shadow      [TileWords];
   bit          tile_written     [TileWords];
   logic [15:0] rowscroll_shadow [ScrollWords];
   bit          rowscroll_written[ScrollWords];
   logic [15:0] colscroll_shadow [ScrollWords];
   bit          colscroll_written[ScrollWords];
   logic [7:0]  pixel_shadow     [int unsigned];

   rsp_payload_type pending_pixels[$];
   int              mismatch_count = 0;

   bit send_gaps_on  = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int rsp_hold_request = 0;

   tilemap_layer_pixel_generator #(
      .GFX_PIXELS(GfxPixels)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int pick_gap(input bit enable);
      int r;
      if (!enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Bias toward both ends of the range.
   function automatic int unsigned pick_value(input int unsigned hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return 0;
      if (r < 40) return hi;
      return $urandom_range(0, hi);
   endfunction

   // Walk one render through the map arithmetic against the shadow state.
   function automatic pixel_path_type trace_pixel(input logic [8:0] sx, input logic [8:0] sy);
      pixel_path_type p;
      int unsigned shape, trow, tsize, wide, high, bsize, mw, mh, yadj, syy, sxx;
      int unsigned row, col, zx, zy, offs, word, code, color, pxl;
      shape = lyr_mode[2:1];
      if (shape == 3) shape = 1;
      trow  = lyr_mode[0] ? ((lyr_wide > 2'd2) ? 3 : int'(lyr_wide) + 1) : 0;
      tsize = lyr_mode[0] ? 16 : 8;
      wide  = MapTiles[trow][shape][0];
      high  = MapTiles[trow][shape][1];
      bsize = MapTiles[trow][0][1];
      mw    = wide * tsize - 1;
      mh    = high * tsize - 1;
      yadj  = {{23{lyr_y_adjust[8]}}, lyr_y_adjust};

      // Vertical: scroll, then column scroll looked up at the wrapped line.
      syy = (sy + ((lyr_scroll_y + yadj) & mh)) & mh;
      p.uses_col = lyr_mode[5];
      p.col_idx  = syy % ScrollWords;
      if (p.uses_col) syy = (syy + colscroll_shadow[p.col_idx]) & mh;

      // Horizontal: scroll, then row scroll at the final line.
      sxx = (sx + (lyr_scroll_x & mw)) & mw;
      p.uses_row = lyr_mode[4];
      p.row_idx  = syy % ScrollWords;
      if (p.uses_row) sxx = (sxx + rowscroll_shadow[p.row_idx]) & mw;

      row = syy / tsize;
      zy  = syy % tsize;
      col = sxx / tsize;
      zx  = sxx % tsize;

      // Tiles are laid out in blocks bsize tiles wide.
      offs       = (col & (bsize - 1)) + row * bsize + (col & ~(bsize - 1)) * high;
      p.tile_idx = offs % TileWords;
      word       = tile_shadow[p.tile_idx];

      color      = ((word >> 12) << lyr_color_shift) | lyr_color_base;
      code       = ((word & 32'hfff) + (lyr_mode[3] ? BankAdd : 0)) & lyr_gfx_mask;
      p.pix_addr = (code * tsize * tsize + zy * tsize + zx) % GfxPixels;
      pxl        = pixel_shadow.exists(p.pix_addr) ? pixel_shadow[p.pix_addr] : 0;

      if (pxl != 0 || lyr_mode[6]) begin
         p.pixel.pixel_value = 16'(pxl + color);
         p.pixel.draw        = 1'b1;
      end else begin
         p.pixel = '0;
      end
      return p;
   endfunction

   function automatic req_payload_type make_item(input logic [2:0] cmd,
                                                 input logic [19:0] addr,
                                                 input logic [15:0] wdata,
                                                 input logic [8:0] sx,
                                                 input logic [8:0] sy);
      req_payload_type item;
      item.cmd      = cmd;
      item.addr     = addr;
      item.wdata    = wdata;
      item.screen_x = sx;
      item.screen_y = sy;
      return item;
   endfunction

   // Offer one item, hold it until the transfer, then update the shadow state.
   task automatic send_item(input req_payload_type item);
      int             gap;
      pixel_path_type p;
      gap = pick_gap(send_gaps_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (cmd_type'(item.cmd))
         CMD_TILE_WR: begin
            tile_shadow[item.addr[TileAddrW-1:0]]  = item.wdata;
            tile_written[item.addr[TileAddrW-1:0]] = 1'b1;
         end
         CMD_ROW_WR: begin
            rowscroll_shadow[item.addr[ScrollAddrW-1:0]]  = item.wdata;
            rowscroll_written[item.addr[ScrollAddrW-1:0]] = 1'b1;
         end
         CMD_COL_WR: begin
            colscroll_shadow[item.addr[ScrollAddrW-1:0]]  = item.wdata;
            colscroll_written[item.addr[ScrollAddrW-1:0]] = 1'b1;
         end
         CMD_PIX_WR: pixel_shadow[int'(item.addr) % GfxPixels] = item.wdata[7:0];
         CMD_RENDER: begin
            p = trace_pixel(item.screen_x, item.screen_y);
            pending_pixels.push_back(p.pixel);
         end
         default: ;
      endcase
   endtask

   task automatic send_write(input cmd_type cmd, input logic [19:0] addr,
                             input logic [15:0] wdata);
      send_item(make_item(cmd, addr, wdata, 9'($urandom), 9'($urandom)));
   endtask

   // Render one pixel. Fill whatever the lookup chain would read that was never
   // written, in chain order, since each fill can move the next address. A forced
   // pixel byte, when given, overwrites the fetched pixel just before the render.
   task automatic send_render(input logic [8:0] sx, input logic [8:0] sy, input int pix_force);
      pixel_path_type p;
      bit             ready_to_go;
      logic [7:0]     pix_byte;
      ready_to_go = 1'b0;
      while (!ready_to_go) begin
         p = trace_pixel(sx, sy);
         pix_byte = ($urandom_range(0, 99) < 20) ? 8'h00 : 8'($urandom);
         if (p.uses_col && !colscroll_written[p.col_idx])
            send_write(CMD_COL_WR, {10'($urandom), 10'(p.col_idx)}, 16'($urandom));
         else if (p.uses_row && !rowscroll_written[p.row_idx])
            send_write(CMD_ROW_WR, {10'($urandom), 10'(p.row_idx)}, 16'($urandom));
         else if (!tile_written[p.tile_idx])
            send_write(CMD_TILE_WR, {8'($urandom), 12'(p.tile_idx)}, 16'($urandom));
         else if (!pixel_shadow.exists(p.pix_addr))
            send_write(CMD_PIX_WR, 20'(p.pix_addr), {8'($urandom), pix_byte});
         else
            ready_to_go = 1'b1;
      end
      if (pix_force >= 0)
         send_write(CMD_PIX_WR, 20'(p.pix_addr), {8'($urandom), 8'(pix_force)});
      send_item(make_item(CMD_RENDER, 20'($urandom), 16'($urandom), sx, sy));
   endtask

   // Drop valid and hold until every render result is back and the pipeline has emptied.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (IdleCycles) @(posedge clock);
   endtask

   // Write all eight registers, one transfer each, with the block idle.
   task automatic set_config(input layer_cfg_type c);
      logic [15:0] d;
      wait_idle();
      for (int i = 0; i < 8; i++) begin
         case (csr_index_type'(i))
            REG_LAYER_MODE:  d = c.mode;
            REG_WIDE_TYPE:   d = c.wide;
            REG_SCROLL_X:    d = c.scroll_x;
            REG_SCROLL_Y:    d = c.scroll_y;
            REG_Y_ADJUST:    d = c.y_adjust;
            REG_COLOR_BASE:  d = c.color_base;
            REG_GFX_MASK:    d = c.gfx_mask;
            default:         d = c.color_shift;
         endcase
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_data  <= d;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (csr_index_type'(i))
            REG_LAYER_MODE:  lyr_mode        = d[6:0];
            REG_WIDE_TYPE:   lyr_wide        = d[1:0];
            REG_SCROLL_X:    lyr_scroll_x    = d;
            REG_SCROLL_Y:    lyr_scroll_y    = d;
            REG_Y_ADJUST:    lyr_y_adjust    = d[8:0];
            REG_COLOR_BASE:  lyr_color_base  = d;
            REG_GFX_MASK:    lyr_gfx_mask    = d[12:0];
            default:         lyr_color_shift = d[3:0];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Random layer setup; upper data bits beyond each register's width carry junk.
   function automatic layer_cfg_type random_cfg();
      layer_cfg_type c;
      int            r;
      c.mode        = {9'($urandom), 7'(pick_value(32'h7f))};
      c.wide        = {14'($urandom), 2'(pick_value(3))};
      c.scroll_x    = 16'(pick_value(32'hffff));
      c.scroll_y    = 16'(pick_value(32'hffff));
      r = $urandom_range(0, 3);
      c.y_adjust    = (r == 0) ? 16'h0100 : (r == 1) ? 16'h00ff : 16'($urandom);
      c.color_base  = 16'(pick_value(32'hffff));
      c.gfx_mask    = {3'($urandom), 13'(pick_value(32'h1fff))};
      c.color_shift = {12'($urandom), 4'(pick_value(15))};
      return c;
   endfunction

   // One random item: mostly renders, then plain writes, then ignored codes.
   task automatic send_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         send_render(9'($urandom), 9'($urandom), -1);
      else if (r < 93)
         send_write(cmd_type'($urandom_range(CMD_TILE_WR, CMD_PIX_WR)),
                    20'($urandom), 16'($urandom));
      else
         send_item(make_item(3'($urandom_range(CmdSpareFirst, CmdSpareLast)),
                             20'($urandom), 16'($urandom), 9'($urandom), 9'($urandom)));
   endtask

   // ---------------------------------------------------------------- tests

   // Reset register values: 8x8 tiles, default mask and shift, corners of the screen.
   task automatic test_reset_defaults();
      send_render(9'h000, 9'h000, -1);
      send_render(9'h1ff, 9'h1ff, -1);
   endtask

   task automatic test_directed_cases();
      layer_cfg_type c;
      // Transparent pixel on a see-through layer yields zero.
      c = ResetCfg;
      set_config(c);
      send_render(9'd3, 9'd5, 0);

      // Opaque layer draws a zero pixel; colour overflow wraps at 16 bits.
      c.mode        = 16'h0040;
      c.color_base  = 16'hffff;
      c.color_shift = 16'd8;
      set_config(c);
      send_render(9'd3, 9'd5, 0);
      send_render(9'd17, 9'd40, 8'hff);

      // Everything at the top: 16x16, shape 3, bank, both scrolls, wide type 3,
      // most negative y adjust, full mask, largest shift.
      c.mode        = 16'h003f;
      c.wide        = 16'd3;
      c.scroll_x    = 16'hffff;
      c.scroll_y    = 16'hffff;
      c.y_adjust    = 16'h0100;
      c.color_base  = 16'h0000;
      c.gfx_mask    = 16'h1fff;
      c.color_shift = 16'd15;
      set_config(c);
      send_render(9'h1ff, 9'h000, -1);
      send_render(9'h000, 9'h1ff, -1);
      send_render(9'h1ff, 9'h1ff, -1);

      // Shape 2 with 16x16 tiles, largest positive y adjust, mask cleared.
      c.mode        = 16'h0035;
      c.wide        = 16'd0;
      c.scroll_x    = 16'h0000;
      c.scroll_y    = 16'h0000;
      c.y_adjust    = 16'h00ff;
      c.color_base  = 16'h8000;
      c.gfx_mask    = 16'h0000;
      c.color_shift = 16'd0;
      set_config(c);
      send_render(9'd0, 9'd0, -1);
      send_render(9'd256, 9'd128, -1);

      // 8x8 tiles with shape 3, wide type ignored for small tiles.
      c.mode = 16'h0006;
      c.wide = 16'd2;
      set_config(c);
      send_render(9'd100, 9'd200, -1);

      // Spare command codes produce nothing.
      for (int cmd = CmdSpareFirst; cmd <= CmdSpareLast; cmd++)
         send_item(make_item(3'(cmd), 20'($urandom), 16'($urandom), 9'($urandom),
                             9'($urandom)));
   endtask

   // Several random setups, with stretches where one side never idles.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         set_config(random_cfg());
         send_gaps_on  = (phase % 3) != 2;
         rsp_stalls_on = (phase % 4) != 3;
         repeat (25) send_random_item();
      end
      send_gaps_on  = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Receiver holds off for a long stretch while renders keep coming, so the
   // pipeline fills and input transfers stop.
   task automatic test_output_backpressure();
      set_config(random_cfg());
      send_gaps_on     = 1'b0;
      rsp_hold_request = 150;
      repeat (40) send_render(9'($urandom), 9'($urandom), -1);
      send_gaps_on = 1'b1;
   endtask

   // Sender stops until every outstanding pixel is back, then resumes.
   task automatic test_drain_pause();
      repeat (30) send_random_item();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (30) send_random_item();
   endtask

   // ---------------------------------------------------------------- checking

   // Compare each result transfer against the oldest expected pixel.
   always @(posedge clock) begin
      rsp_payload_type exp_pixel;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result: expected none, got value %h draw %b",
                     $time, rsp_payload.pixel_value, rsp_payload.draw);
            mismatch_count++;
         end else begin
            exp_pixel = pending_pixels.pop_front();
            if (rsp_payload.pixel_value !== exp_pixel.pixel_value) begin
               $display("%0t: pixel_value mismatch: expected %h, got %h",
                        $time, exp_pixel.pixel_value, rsp_payload.pixel_value);
               mismatch_count++;
            end
            if (rsp_payload.draw !== exp_pixel.draw) begin
               $display("%0t: draw mismatch: expected %b, got %b",
                        $time, exp_pixel.draw, rsp_payload.draw);
               mismatch_count++;
            end
         end
      end
   end

   // Result-side ready: random stalls, plus a long hold-off on request.
   initial begin
      int stall;
      stall     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            stall            = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall == 0) begin
            stall = pick_gap(rsp_stalls_on);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Hard stop if the run hangs.
   initial begin
      #12000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int waited;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      lyr_mode        = ResetCfg.mode[6:0];
      lyr_wide        = ResetCfg.wide[1:0];
      lyr_scroll_x    = ResetCfg.scroll_x;
      lyr_scroll_y    = ResetCfg.scroll_y;
      lyr_y_adjust    = ResetCfg.y_adjust[8:0];
      lyr_color_base  = ResetCfg.color_base;
      lyr_gfx_mask    = ResetCfg.gfx_mask[12:0];
      lyr_color_shift = ResetCfg.color_shift[3:0];
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_cases();
      test_random_traffic();
      test_output_backpressure();
      test_drain_pause();

      // Drain: wait for the last pixels, bounded, then let the pipeline settle.
      req_valid <= 1'b0;
      waited = 0;
      while (pending_pixels.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (pending_pixels.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_pixels.size());
         $display("status: fail");
         $finish;
      end else begin
         repeat (DrainCycles) @(posedge clock);
         if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("status: pass");
         end else begin
            $display("status: fail");
         end
         $finish;
      end
   end

endmodule
